// ----- rtl/core/mrre_pkg.sv -----
// Shared types, constants and the request plan struct for the Modbus request engine.
// Used by mrre_decode and modbus_register_request_engine; depends on nothing.

package mrre_pkg;

  // Register file size and node range
  localparam int REGISTER_COUNT = 64;
  localparam int NODE_COUNT     = 2;
  localparam int ADDR_W         = $clog2(REGISTER_COUNT);

  // Field widths
  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 8;

  // Protocol constants
  localparam logic [9:0]  MIN_FRAME     = 10'd9;
  localparam logic [15:0] MAX_READ      = 16'd125;
  localparam logic [15:0] RESET_MAGIC   = 16'h0055;
  localparam logic [15:0] DATA_ZONE_END = 16'h0020;
  localparam logic [7:0]  EXC_FLAG      = 8'h80;
  localparam logic [7:0]  EXC_UNIT      = 8'hFF;
  localparam logic [15:0] HEADER_EXTRA  = 16'd6;

  // Function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;

  // Exception codes
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RESET_CTRL   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_CTRL = 8'd1;

  typedef enum logic [1:0] {
    ST_RESPONSE   = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_UPDATED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SE_NONE         = 2'd0,
    SE_BUS_RESET    = 2'd1,
    SE_NODE_RELEASE = 2'd2
  } side_t;

  typedef enum logic {
    PLAN_SINGLE = 1'b0,
    PLAN_READ   = 1'b1
  } plan_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_EXEC  = 3'd2,
    S_FETCH = 3'd3,
    S_WORD1 = 3'd4,
    S_EMIT  = 3'd5
  } state_t;

  // What one accepted word asks of the engine
  typedef struct packed {
    plan_kind_t          kind;
    status_t             status;
    logic [15:0]         tid;
    logic [7:0]          unit;
    logic [7:0]          func;
    logic [7:0]          info;
    logic [15:0]         first_word;
    logic [15:0]         second_word;
    logic [1:0]          words_valid;
    side_t               side;
    logic [4:0]          node;
    logic                err_inc;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [15:0]         wr_data;
    logic [ADDR_W-1:0]   rd_start;
    logic [COUNT_W-1:0]  rd_count;
  } plan_t;

endpackage

// ----- rtl/core/modbus_register_request_engine.sv -----
// Modbus TCP holding-register request engine, top level.
// Depends on mrre_pkg, mrre_ram and mrre_decode.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one decoded request or local update
//   word. Output channel (out_valid/out_ready) delivers result words; last marks
//   the final word of a request. The config channel (cfg_valid/cfg_ready, always
//   ready) writes the reset and release control addresses by index.
// Sequencing:
//   A single-result request is accepted in S_IDLE; in S_EXEC its result is
//   loaded into the output register once the output is free, and the engine
//   goes back to S_IDLE for the next word. A register read streams result words
//   of up to two registers each through S_FETCH, S_WORD1 and S_EMIT (two reads
//   on the single read port of the register RAM plus the output load), holding
//   in S_EMIT while the output is not free. One request is worked on at a time.
// Reset:
//   rst clears control state and the error counter, restores the control
//   addresses, then sweeps the register RAM to zero, one entry per cycle,
//   during which in_ready stays low. Config writes are taken throughout.
// Stalls:
//   The result sits in an output register; while it is untaken and out_ready
//   is low the engine holds, and the next input word can already be taken once
//   the current request has loaded its last result.

module modbus_register_request_engine (
  input  logic                             clk,
  input  logic                             rst,
  // Request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [9:0]                       frame_length,
  input  logic [15:0]                      protocol_id,
  input  logic [15:0]                      header_length,
  input  logic [15:0]                      transaction_id,
  input  logic [7:0]                       unit_id,
  input  logic [7:0]                       function_code,
  input  logic [15:0]                      address,
  input  logic [15:0]                      data_word,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [15:0]                      transaction_out,
  output logic [7:0]                       unit_out,
  output logic [7:0]                       function_out,
  output logic [7:0]                       info_byte,
  output logic [15:0]                      first_word,
  output logic [15:0]                      second_word,
  output logic [1:0]                       words_valid,
  output logic [1:0]                       side_effect,
  output logic [4:0]                       released_node,
  output logic [15:0]                      error_total,
  output logic                             last,
  // Config channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mrre_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data
);

  localparam logic [mrre_pkg::ADDR_W-1:0] LAST_ENTRY =
    mrre_pkg::ADDR_W'(mrre_pkg::REGISTER_COUNT - 1);

  mrre_pkg::state_t state, state_next;
  mrre_pkg::plan_t  dec_plan;
  mrre_pkg::plan_t  plan;

  logic [15:0]                   reset_ctrl_addr;
  logic [15:0]                   release_ctrl_addr;
  logic [15:0]                   error_count;
  logic [15:0]                   error_count_next;
  logic [mrre_pkg::ADDR_W-1:0]   ptr;
  logic [mrre_pkg::COUNT_W-1:0]  remaining;
  logic [15:0]                   w1;
  logic                          two_left;
  logic                          out_free;
  logic                          out_load;
  logic                          in_accept;

  logic                          ram_wr_en;
  logic [mrre_pkg::ADDR_W-1:0]   ram_wr_addr;
  logic [15:0]                   ram_wr_data;
  logic                          ram_rd_en;
  logic [mrre_pkg::ADDR_W-1:0]   ram_rd_addr;
  logic [15:0]                   ram_rd_data;

  mrre_pkg::status_t             out_status;
  mrre_pkg::side_t               out_side;

  // Classify the word on the input ports
  mrre_decode u_decode (
    .action            (action),
    .frame_length      (frame_length),
    .protocol_id       (protocol_id),
    .header_length     (header_length),
    .transaction_id    (transaction_id),
    .unit_id           (unit_id),
    .function_code     (function_code),
    .address           (address),
    .data_word         (data_word),
    .reset_ctrl_addr   (reset_ctrl_addr),
    .release_ctrl_addr (release_ctrl_addr),
    .plan              (dec_plan)
  );

  // Holding register file
  mrre_ram #(
    .WIDTH (16),
    .DEPTH (mrre_pkg::REGISTER_COUNT)
  ) u_regfile (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign two_left  = remaining > mrre_pkg::COUNT_W'(1);

  // Count errors only on the load of a single-result word that asks for it
  assign error_count_next = error_count +
    16'(out_load && (state == mrre_pkg::S_EXEC) && plan.err_inc);

  // Control addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_ctrl_addr   <= 16'h0020;
      release_ctrl_addr <= 16'h0021;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrre_pkg::CFG_RESET_CTRL:   reset_ctrl_addr   <= cfg_data;
        mrre_pkg::CFG_RELEASE_CTRL: release_ctrl_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrre_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM access and handshake control
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = ptr;
    ram_wr_data = 16'd0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = ptr;
    unique case (state)
      mrre_pkg::S_CLEAR: begin
        ram_wr_en = 1'b1;
        if (ptr == LAST_ENTRY) begin
          state_next = mrre_pkg::S_IDLE;
        end
      end
      mrre_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = mrre_pkg::S_EXEC;
        end
      end
      mrre_pkg::S_EXEC: begin
        if (plan.kind == mrre_pkg::PLAN_READ) begin
          state_next = mrre_pkg::S_FETCH;
        end else if (out_free) begin
          out_load    = 1'b1;
          ram_wr_en   = plan.wr_en;
          ram_wr_addr = plan.wr_addr;
          ram_wr_data = plan.wr_data;
          state_next  = mrre_pkg::S_IDLE;
        end
      end
      mrre_pkg::S_FETCH: begin
        ram_rd_en  = 1'b1;
        state_next = mrre_pkg::S_WORD1;
      end
      mrre_pkg::S_WORD1: begin
        ram_rd_en   = two_left;
        ram_rd_addr = ptr + mrre_pkg::ADDR_W'(1);
        state_next  = mrre_pkg::S_EMIT;
      end
      mrre_pkg::S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (remaining <= mrre_pkg::COUNT_W'(2)) ? mrre_pkg::S_IDLE :
                                                             mrre_pkg::S_FETCH;
        end
      end
      default: state_next = mrre_pkg::S_IDLE;
    endcase
  end

  // Clear pointer and read walk
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (state == mrre_pkg::S_CLEAR) begin
      ptr <= ptr + mrre_pkg::ADDR_W'(1);
    end else if ((state == mrre_pkg::S_EXEC) && (plan.kind == mrre_pkg::PLAN_READ)) begin
      ptr <= plan.rd_start;
    end else if ((state == mrre_pkg::S_EMIT) && out_load) begin
      ptr <= ptr + mrre_pkg::ADDR_W'(2);
    end
  end

  // Hold the plan, the word count and the first word of a pair
  always_ff @(posedge clk) begin
    if (in_accept) begin
      plan <= dec_plan;
    end
    if (state == mrre_pkg::S_EXEC) begin
      remaining <= plan.rd_count;
    end else if ((state == mrre_pkg::S_EMIT) && out_load) begin
      remaining <= remaining - mrre_pkg::COUNT_W'(2);
    end
    if (state == mrre_pkg::S_WORD1) begin
      w1 <= ram_rd_data;
    end
  end

  // Error counter
  always_ff @(posedge clk) begin
    if (rst) begin
      error_count <= 16'd0;
    end else begin
      error_count <= error_count_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      transaction_out <= plan.tid;
      unit_out        <= plan.unit;
      function_out    <= plan.func;
      info_byte       <= plan.info;
      error_total     <= error_count_next;
      if (state == mrre_pkg::S_EXEC) begin
        out_status    <= plan.status;
        first_word    <= plan.first_word;
        second_word   <= plan.second_word;
        words_valid   <= plan.words_valid;
        out_side      <= plan.side;
        released_node <= plan.node;
        last          <= 1'b1;
      end else begin
        out_status    <= mrre_pkg::ST_RESPONSE;
        first_word    <= w1;
        second_word   <= two_left ? ram_rd_data : 16'd0;
        words_valid   <= two_left ? 2'd2 : 2'd1;
        out_side      <= mrre_pkg::SE_NONE;
        released_node <= 5'd0;
        last          <= remaining <= mrre_pkg::COUNT_W'(2);
      end
    end
  end

  assign status      = out_status;
  assign side_effect = out_side;

  // One request at a time: the cycle after an accept takes nothing new
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("input taken while a request is in progress");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result register loaded while holding an untaken word");

  // The register RAM is never read and written in the same cycle
  a_ram_exclusive: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> !ram_rd_en)
    else $error("register RAM read and written in one cycle");

  // A read burst only emits while registers remain
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == mrre_pkg::S_EMIT) |-> (remaining != '0))
    else $error("read burst emitting with no registers left");

endmodule

// ----- rtl/core/mrre_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module mrre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/mrre_decode.sv -----
// Request classifier: turns one input word and the control addresses into a plan.
// Depends on mrre_pkg.

module mrre_decode (
  input  logic                  action,
  input  logic [9:0]            frame_length,
  input  logic [15:0]           protocol_id,
  input  logic [15:0]           header_length,
  input  logic [15:0]           transaction_id,
  input  logic [7:0]            unit_id,
  input  logic [7:0]            function_code,
  input  logic [15:0]           address,
  input  logic [15:0]           data_word,
  input  logic [15:0]           reset_ctrl_addr,
  input  logic [15:0]           release_ctrl_addr,
  output mrre_pkg::plan_t       plan
);

  logic        addr_in_file;
  logic        short_frame;
  logic        incomplete;
  logic        read_bad;
  logic [16:0] read_end;
  logic [16:0] frame_need;
  logic        is_reset_ctrl;
  logic        is_release_ctrl;

  // Range checks, all without wrap
  always_comb begin
    addr_in_file    = address < 16'(mrre_pkg::REGISTER_COUNT);
    short_frame     = frame_length < mrre_pkg::MIN_FRAME;
    frame_need      = {1'b0, header_length} + {1'b0, mrre_pkg::HEADER_EXTRA};
    incomplete      = frame_need > {7'd0, frame_length};
    read_end        = {1'b0, address} + {1'b0, data_word};
    read_bad        = (data_word == 16'd0) || (data_word > mrre_pkg::MAX_READ) ||
                      (read_end > 17'(mrre_pkg::REGISTER_COUNT));
    is_reset_ctrl   = (address == reset_ctrl_addr) && (data_word == mrre_pkg::RESET_MAGIC);
    is_release_ctrl = (address == release_ctrl_addr) && (data_word != 16'd0) &&
                      (data_word <= 16'(mrre_pkg::NODE_COUNT));
  end

  // Build the plan in priority order
  always_comb begin
    plan          = '0;
    plan.kind     = mrre_pkg::PLAN_SINGLE;
    plan.status   = mrre_pkg::ST_RESPONSE;
    plan.side     = mrre_pkg::SE_NONE;
    plan.wr_addr  = address[mrre_pkg::ADDR_W-1:0];
    plan.wr_data  = data_word;
    plan.rd_start = address[mrre_pkg::ADDR_W-1:0];
    plan.rd_count = data_word[mrre_pkg::COUNT_W-1:0];
    if (action) begin
      plan.status = mrre_pkg::ST_UPDATED;
      plan.wr_en  = addr_in_file;
    end else if (short_frame || (protocol_id != 16'd0)) begin
      plan.status  = mrre_pkg::ST_DROPPED;
      plan.err_inc = 1'b1;
    end else if (incomplete) begin
      plan.status = mrre_pkg::ST_INCOMPLETE;
    end else if (function_code == mrre_pkg::FC_READ_HOLDING) begin
      plan.tid = transaction_id;
      if (read_bad) begin
        plan.unit = mrre_pkg::EXC_UNIT;
        plan.func = mrre_pkg::FC_READ_HOLDING | mrre_pkg::EXC_FLAG;
        plan.info = mrre_pkg::EXC_ILLEGAL_ADDRESS;
      end else begin
        plan.kind = mrre_pkg::PLAN_READ;
        plan.unit = unit_id;
        plan.func = mrre_pkg::FC_READ_HOLDING;
        plan.info = {data_word[mrre_pkg::COUNT_W-1:0], 1'b0};
      end
    end else if (function_code == mrre_pkg::FC_WRITE_SINGLE) begin
      plan.tid = transaction_id;
      if (!addr_in_file) begin
        plan.unit = mrre_pkg::EXC_UNIT;
        plan.func = mrre_pkg::FC_WRITE_SINGLE | mrre_pkg::EXC_FLAG;
        plan.info = mrre_pkg::EXC_ILLEGAL_ADDRESS;
      end else begin
        plan.unit        = unit_id;
        plan.func        = mrre_pkg::FC_WRITE_SINGLE;
        plan.first_word  = address;
        plan.second_word = data_word;
        plan.words_valid = 2'd2;
        if (is_reset_ctrl) begin
          plan.side = mrre_pkg::SE_BUS_RESET;
        end else if (is_release_ctrl) begin
          plan.side = mrre_pkg::SE_NODE_RELEASE;
          plan.node = data_word[4:0];
        end else begin
          plan.wr_en = address >= mrre_pkg::DATA_ZONE_END;
        end
      end
    end else begin
      plan.tid     = transaction_id;
      plan.unit    = mrre_pkg::EXC_UNIT;
      plan.func    = function_code | mrre_pkg::EXC_FLAG;
      plan.info    = mrre_pkg::EXC_ILLEGAL_FUNCTION;
      plan.err_inc = 1'b1;
    end
  end

endmodule
